// ----- src/clear_normalized_rgb_to_hsl_assert.svh -----
// ----------------------------------------------------------------------------
// rgb to hsl assertion macros
// shared property shapes for the checker, clocked on clk; the same-cycle one is off in rst
// ----------------------------------------------------------------------------
`ifndef CLEAR_NORMALIZED_RGB_TO_HSL_ASSERT_SVH
`define CLEAR_NORMALIZED_RGB_TO_HSL_ASSERT_SVH

// same-cycle implication, off while in reset
`define CNH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define CNH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cnh_pkg.sv -----
// ----------------------------------------------------------------------------
// rgb to hsl package
// item types, widths and constants shared by the conversion pipeline
// ----------------------------------------------------------------------------
package cnh_pkg;

  localparam int COUNT_BITS   = 16;
  localparam int FIELD_BITS   = 16;
  localparam int PCT_BITS     = 7;
  localparam int HUE_BITS     = 9;
  localparam int SUM_BITS     = PCT_BITS + 1;
  localparam int HUE_NUM_BITS = 13;
  localparam int SAT_NUM_BITS = 14;

  // pipelined divider: saturating quotient, two restoring steps a stage after the first
  localparam int DIV_Q_BITS   = PCT_BITS;
  localparam int DIV_DEN_BITS = COUNT_BITS;
  localparam int DIV_NUM_BITS = COUNT_BITS + DIV_Q_BITS;
  localparam int DIV_STAGES   = (DIV_Q_BITS + 1) / 2;

  localparam logic [PCT_BITS-1:0]     PCT_FULL      = 7'd100;
  localparam logic [PCT_BITS-1:0]     LIGHT_SPLIT   = 7'd50;
  localparam logic [SUM_BITS-1:0]     SUM_FULL      = 8'd200;
  localparam logic [HUE_NUM_BITS-1:0] SECTOR_DEG    = 13'd60;
  localparam logic [HUE_BITS-1:0]     HUE_GREEN_DEG = 9'd120;
  localparam logic [HUE_BITS-1:0]     HUE_BLUE_DEG  = 9'd240;
  localparam logic [HUE_BITS-1:0]     HUE_WRAP_DEG  = 9'd360;

  typedef enum logic [1:0] {
    MAX_RED   = 2'd0,
    MAX_GREEN = 2'd1,
    MAX_BLUE  = 2'd2
  } max_sel_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] red_count;
    logic [FIELD_BITS-1:0] green_count;
    logic [FIELD_BITS-1:0] blue_count;
    logic [FIELD_BITS-1:0] clear_count;
  } sample_t;

  typedef struct packed {
    logic [HUE_BITS-1:0] hue_degrees;
    logic [PCT_BITS-1:0] saturation_pct;
    logic [PCT_BITS-1:0] lightness_pct;
    logic                clear_zero;
  } result_t;

  // saturated quotients from the percent dividers
  typedef struct packed {
    logic [PCT_BITS-1:0] red;
    logic [PCT_BITS-1:0] green;
    logic [PCT_BITS-1:0] blue;
    logic                clear_zero;
  } pct_t;

  // operands and flags for the hue and saturation divides
  typedef struct packed {
    logic                    clear_zero;
    logic                    gray;
    max_sel_t                max_sel;
    logic                    hue_neg;
    logic [HUE_NUM_BITS-1:0] hue_num;
    logic [PCT_BITS-1:0]     hue_den;
    logic [SAT_NUM_BITS-1:0] sat_num;
    logic [SUM_BITS-1:0]     sat_den;
    logic                    sat_den_zero;
    logic [PCT_BITS-1:0]     light;
  } prep_t;

endpackage

// ----- src/cnh_div.sv -----
// ----------------------------------------------------------------------------
// pipelined saturating divider
// restoring division, two quotient bits per stage after the first, quotient clipped to all ones
// ----------------------------------------------------------------------------
module cnh_div (
  input  logic                               clk,
  input  logic                               advance,
  input  logic [cnh_pkg::DIV_NUM_BITS-1:0]   num,
  input  logic [cnh_pkg::DIV_DEN_BITS-1:0]   den,
  output logic [cnh_pkg::DIV_Q_BITS-1:0]     quo
);
  import cnh_pkg::*;

  typedef struct packed {
    logic [DIV_NUM_BITS-1:0] rem;
    logic [DIV_DEN_BITS-1:0] den;
    logic [DIV_Q_BITS-1:0]   quo;
    logic                    sat;
  } div_state_t;

  function automatic div_state_t div_step(div_state_t st, int k);
    div_state_t              res;
    logic [DIV_NUM_BITS-1:0] shifted;
    res     = st;
    shifted = {{(DIV_NUM_BITS-DIV_DEN_BITS){1'b0}}, st.den} << k;
    if (st.rem >= shifted) begin
      res.rem    = st.rem - shifted;
      res.quo[k] = 1'b1;
    end
    return res;
  endfunction

  div_state_t stage      [DIV_STAGES];
  div_state_t stage_next [DIV_STAGES];

  always_comb begin
    div_state_t head;
    head.rem = num;
    head.den = den;
    head.quo = '0;
    // quotient would not fit: clip at the end
    head.sat = (num[DIV_NUM_BITS-1:DIV_Q_BITS] >= den);
    stage_next[0] = div_step(head, DIV_Q_BITS - 1);
    for (int s = 1; s < DIV_STAGES; s++) begin
      stage_next[s] = div_step(div_step(stage[s-1], DIV_Q_BITS - 2*s),
                               DIV_Q_BITS - 1 - 2*s);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage <= stage_next;
    end
  end

  assign quo = stage[DIV_STAGES-1].sat ? '1 : stage[DIV_STAGES-1].quo;

endmodule

// ----- src/cnh_prep.sv -----
// ----------------------------------------------------------------------------
// hsl operand preparation
// two stages: clamp and max/min pick, then lightness and divide operands
// ----------------------------------------------------------------------------
module cnh_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           pct_valid,
  input  cnh_pkg::pct_t  pct,
  output logic           prep_valid,
  output cnh_pkg::prep_t prep
);
  import cnh_pkg::*;

  logic                valid_a;
  logic [PCT_BITS-1:0] red_a, green_a, blue_a, max_a, min_a;
  max_sel_t            sel_a;
  logic                clear_zero_a;

  logic [PCT_BITS-1:0] red_c, green_c, blue_c;
  logic [PCT_BITS-1:0] max_next, min_next;
  max_sel_t            sel_next;
  prep_t               prep_next;

  logic [PCT_BITS-1:0] dif, op_x, op_y, mag;
  logic [SUM_BITS-1:0] sum;

  // stage a: clamp to full scale, pick max and min
  always_comb begin
    red_c   = (pct.red   > PCT_FULL) ? PCT_FULL : pct.red;
    green_c = (pct.green > PCT_FULL) ? PCT_FULL : pct.green;
    blue_c  = (pct.blue  > PCT_FULL) ? PCT_FULL : pct.blue;

    // ties go to red, then green
    if (red_c >= green_c && red_c >= blue_c) begin
      sel_next = MAX_RED;
      max_next = red_c;
    end else if (green_c >= blue_c) begin
      sel_next = MAX_GREEN;
      max_next = green_c;
    end else begin
      sel_next = MAX_BLUE;
      max_next = blue_c;
    end

    min_next = red_c;
    if (green_c < min_next) min_next = green_c;
    if (blue_c < min_next) min_next = blue_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (advance) begin
      valid_a <= pct_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red_a        <= red_c;
      green_a      <= green_c;
      blue_a       <= blue_c;
      max_a        <= max_next;
      min_a        <= min_next;
      sel_a        <= sel_next;
      clear_zero_a <= pct.clear_zero;
    end
  end

  // stage b: sector difference, lightness and saturation denominator
  always_comb begin
    dif = max_a - min_a;
    sum = SUM_BITS'(max_a) + SUM_BITS'(min_a);

    case (sel_a)
      MAX_RED: begin
        op_x = green_a;
        op_y = blue_a;
      end
      MAX_GREEN: begin
        op_x = blue_a;
        op_y = red_a;
      end
      MAX_BLUE: begin
        op_x = red_a;
        op_y = green_a;
      end
      default: begin
        op_x = '0;
        op_y = '0;
      end
    endcase
    mag = (op_x < op_y) ? (op_y - op_x) : (op_x - op_y);

    prep_next.clear_zero = clear_zero_a;
    prep_next.gray       = (dif == '0);
    prep_next.max_sel    = sel_a;
    prep_next.hue_neg    = (op_x < op_y);
    prep_next.hue_num    = HUE_NUM_BITS'(mag) * SECTOR_DEG;
    prep_next.hue_den    = dif;
    prep_next.sat_num    = SAT_NUM_BITS'(dif) * SAT_NUM_BITS'(PCT_FULL);
    prep_next.light      = sum[SUM_BITS-1:1];
    if (sum[SUM_BITS-1:1] <= LIGHT_SPLIT) begin
      prep_next.sat_den = sum;
    end else begin
      prep_next.sat_den = SUM_FULL - sum;
    end
    prep_next.sat_den_zero = (prep_next.sat_den == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_valid <= 1'b0;
    end else if (advance) begin
      prep_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prep <= prep_next;
    end
  end

endmodule

// ----- src/cnh_skid.sv -----
// ----------------------------------------------------------------------------
// output register with skid stage
// holds one result for the receiver and one more, so the pipeline
// stall depends on a register only
// ----------------------------------------------------------------------------
module cnh_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cnh_pkg::result_t push_item,
  output logic             advance,
  output logic             result_valid,
  input  logic             result_ready,
  output cnh_pkg::result_t result
);
  import cnh_pkg::*;

  logic    skid_full;
  result_t skid;

  // pipeline moves while the skid slot is free
  assign advance = !skid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (result_valid && !result_ready) begin
      if (push) begin
        skid_full <= 1'b1;
      end
    end else if (skid_full) begin
      result_valid <= 1'b1;
      skid_full    <= 1'b0;
    end else begin
      result_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !result_ready) begin
      if (push) begin
        skid <= push_item;
      end
    end else if (skid_full) begin
      result <= skid;
    end else if (push) begin
      result <= push_item;
    end
  end

endmodule

// ----- src/clear_normalized_rgb_to_hsl.sv -----
// ----------------------------------------------------------------------------
// clear normalised rgb to hsl converter
// One raw colour sample (red, green, blue, clear counts) enters on the sample
// channel; one hue/saturation/lightness result leaves on the result channel.
// Both channels are valid/ready; a transfer happens when valid and ready are
// high at a rising edge of clk.
// Each colour is scaled to percent of clear and clamped to 100; a zero clear
// count gives clear_zero with all other fields zero.
// Throughput: one sample per cycle while sample_ready is high. The pipeline
// is twelve registers deep: an input stage, a four-stage percent divider,
// two preparation stages, a four-stage hue and saturation divider and the
// output register.
// A stalled receiver fills the output register and then one skid entry;
// sample_ready then drops until the receiver takes the held result.
// Reset (rst, synchronous) empties every stage and the output; sample_ready
// is high from the first cycle after reset.
// ----------------------------------------------------------------------------
module clear_normalized_rgb_to_hsl (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  cnh_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output cnh_pkg::result_t result
);
  import cnh_pkg::*;

  logic advance;

  // input stage: numerators for the percent divides
  logic                    in_valid;
  logic [DIV_NUM_BITS-1:0] num_red, num_green, num_blue;
  logic [DIV_DEN_BITS-1:0] clear_den;
  logic                    in_clear_zero;

  logic [DIV_Q_BITS-1:0]   q_red, q_green, q_blue;
  logic [DIV_STAGES-1:0]   pct_valid_line;
  logic [DIV_STAGES-1:0]   clear_zero_line;
  pct_t                    pct;

  logic                    prep_valid;
  prep_t                   prep;

  logic [DIV_STAGES-1:0]   hsl_valid_line;
  prep_t                   side_line [DIV_STAGES];
  logic [DIV_Q_BITS-1:0]   q_hue, q_sat;

  prep_t                   side;
  logic [HUE_BITS-1:0]     hue_base;
  result_t                 push_item;

  assign sample_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (advance) begin
      in_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      num_red       <= DIV_NUM_BITS'(sample.red_count[COUNT_BITS-1:0]) *
                       DIV_NUM_BITS'(PCT_FULL);
      num_green     <= DIV_NUM_BITS'(sample.green_count[COUNT_BITS-1:0]) *
                       DIV_NUM_BITS'(PCT_FULL);
      num_blue      <= DIV_NUM_BITS'(sample.blue_count[COUNT_BITS-1:0]) *
                       DIV_NUM_BITS'(PCT_FULL);
      clear_den     <= sample.clear_count[COUNT_BITS-1:0];
      in_clear_zero <= (sample.clear_count[COUNT_BITS-1:0] == '0);
    end
  end

  cnh_div u_div_red (
    .clk     (clk),
    .advance (advance),
    .num     (num_red),
    .den     (clear_den),
    .quo     (q_red)
  );

  cnh_div u_div_green (
    .clk     (clk),
    .advance (advance),
    .num     (num_green),
    .den     (clear_den),
    .quo     (q_green)
  );

  cnh_div u_div_blue (
    .clk     (clk),
    .advance (advance),
    .num     (num_blue),
    .den     (clear_den),
    .quo     (q_blue)
  );

  // valid and zero-clear flag ride alongside the percent divider
  always_ff @(posedge clk) begin
    if (rst) begin
      pct_valid_line <= '0;
    end else if (advance) begin
      pct_valid_line <= {pct_valid_line[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      clear_zero_line <= {clear_zero_line[DIV_STAGES-2:0], in_clear_zero};
    end
  end

  assign pct.red        = q_red;
  assign pct.green      = q_green;
  assign pct.blue       = q_blue;
  assign pct.clear_zero = clear_zero_line[DIV_STAGES-1];

  cnh_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .pct_valid  (pct_valid_line[DIV_STAGES-1]),
    .pct        (pct),
    .prep_valid (prep_valid),
    .prep       (prep)
  );

  cnh_div u_div_hue (
    .clk     (clk),
    .advance (advance),
    .num     (DIV_NUM_BITS'(prep.hue_num)),
    .den     (DIV_DEN_BITS'(prep.hue_den)),
    .quo     (q_hue)
  );

  cnh_div u_div_sat (
    .clk     (clk),
    .advance (advance),
    .num     (DIV_NUM_BITS'(prep.sat_num)),
    .den     (DIV_DEN_BITS'(prep.sat_den)),
    .quo     (q_sat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hsl_valid_line <= '0;
    end else if (advance) begin
      hsl_valid_line <= {hsl_valid_line[DIV_STAGES-2:0], prep_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      side_line[0] <= prep;
      for (int i = 1; i < DIV_STAGES; i++) begin
        side_line[i] <= side_line[i-1];
      end
    end
  end

  // final assembly: sector offset, clamps and special cases
  always_comb begin
    side = side_line[DIV_STAGES-1];

    case (side.max_sel)
      MAX_RED:   hue_base = side.hue_neg ? HUE_WRAP_DEG : '0;
      MAX_GREEN: hue_base = HUE_GREEN_DEG;
      MAX_BLUE:  hue_base = HUE_BLUE_DEG;
      default:   hue_base = '0;
    endcase

    push_item.clear_zero    = 1'b0;
    push_item.lightness_pct = side.light;
    if (side.hue_neg) begin
      push_item.hue_degrees = hue_base - HUE_BITS'(q_hue);
    end else begin
      push_item.hue_degrees = hue_base + HUE_BITS'(q_hue);
    end
    if (side.sat_den_zero) begin
      push_item.saturation_pct = '0;
    end else begin
      push_item.saturation_pct = (q_sat > PCT_FULL) ? PCT_FULL : q_sat;
    end

    if (side.clear_zero) begin
      push_item.hue_degrees    = '0;
      push_item.saturation_pct = '0;
      push_item.lightness_pct  = '0;
      push_item.clear_zero     = 1'b1;
    end else if (side.gray) begin
      push_item.hue_degrees    = '0;
      push_item.saturation_pct = '0;
    end
  end

  cnh_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (advance && hsl_valid_line[DIV_STAGES-1]),
    .push_item    (push_item),
    .advance      (advance),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- src/cnh_checker.sv -----
// ----------------------------------------------------------------------------
// rgb to hsl port checker
// watches the top level ports for range, zero-clear, stall and reset behaviour
// ----------------------------------------------------------------------------
`include "clear_normalized_rgb_to_hsl_assert.svh"

module cnh_checker (
  input logic             clk,
  input logic             rst,
  input logic             sample_ready,
  input logic             result_valid,
  input logic             result_ready,
  input cnh_pkg::result_t result
);
  import cnh_pkg::*;

  // results stay inside their ranges
  `CNH_ASSERT_NOW(a_result_range, result_valid, result.hue_degrees <= HUE_WRAP_DEG && result.saturation_pct <= PCT_FULL && result.lightness_pct <= PCT_FULL, "result field out of range")

  // zero clear count blanks the colour fields
  `CNH_ASSERT_NOW(a_clear_zero_blank, result_valid && result.clear_zero, result.hue_degrees == '0 && result.saturation_pct == '0 && result.lightness_pct == '0, "clear_zero result with non-zero fields")

  // a held result does not move
  `CNH_ASSERT_NEXT(a_result_hold, !rst && result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")

  // reset leaves the output empty and the input open
  `CNH_ASSERT_NEXT(a_reset_state, rst, !result_valid && sample_ready, "bad state after reset")

endmodule

bind clear_normalized_rgb_to_hsl cnh_checker u_cnh_checker (.*);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// rgb to hsl converter testbench
// Drives colour samples over the valid/ready sample channel with random gaps
// and random result stalls. Each sample's hue, saturation and lightness are
// computed or hand-worked, compared field by field, in order, with results.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cnh_pkg::*;

  localparam int RANDOM_SAMPLES = 1030;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 24;

  typedef struct packed {
    logic    typed;
    sample_t s;
    result_t r;
  } stim_row_t;

  typedef struct packed {
    sample_t s;
    result_t r;
  } pending_t;

  localparam int N_ROWS = 22;

  // hand-worked rows carry their answer, the rest go through hsl_of
  localparam stim_row_t DIRECTED [N_ROWS] = '{
    '{1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, '{9'd0,   7'd0,   7'd0,   1'b1}},
    '{1'b1, '{16'hffff, 16'hffff, 16'hffff, 16'hffff}, '{9'd0,   7'd0,   7'd100, 1'b0}},
    '{1'b1, '{16'hffff, 16'hffff, 16'hffff, 16'h0000}, '{9'd0,   7'd0,   7'd0,   1'b1}},
    '{1'b1, '{16'h0000, 16'h0000, 16'h0000, 16'hffff}, '{9'd0,   7'd0,   7'd0,   1'b0}},
    '{1'b1, '{16'hffff, 16'hffff, 16'hffff, 16'h0001}, '{9'd0,   7'd0,   7'd100, 1'b0}},
    '{1'b1, '{16'hffff, 16'h0000, 16'h0000, 16'hffff}, '{9'd0,   7'd100, 7'd50,  1'b0}},
    '{1'b1, '{16'h0000, 16'hffff, 16'h0000, 16'hffff}, '{9'd120, 7'd100, 7'd50,  1'b0}},
    '{1'b1, '{16'h0000, 16'h0000, 16'hffff, 16'hffff}, '{9'd240, 7'd100, 7'd50,  1'b0}},
    '{1'b1, '{16'd100,  16'd0,    16'd1,    16'd100},  '{9'd360, 7'd100, 7'd50,  1'b0}},
    '{1'b0, '{16'd100,  16'd100,  16'd50,   16'd100},  '0},
    '{1'b1, '{16'd50,   16'd50,   16'd50,   16'd100},  '{9'd0,   7'd0,   7'd50,  1'b0}},
    '{1'b0, '{16'd100,  16'd100,  16'd0,    16'd100},  '0},
    '{1'b0, '{16'd0,    16'd100,  16'd100,  16'd100},  '0},
    '{1'b0, '{16'd50,   16'd100,  16'd0,    16'd100},  '0},
    '{1'b0, '{16'd0,    16'd50,   16'd100,  16'd100},  '0},
    '{1'b0, '{16'd100,  16'd30,   16'd60,   16'd100},  '0},
    '{1'b0, '{16'd80,   16'd20,   16'd80,   16'd100},  '0},
    '{1'b0, '{16'd100,  16'd90,   16'd80,   16'd100},  '0},
    '{1'b0, '{16'haaaa, 16'h5555, 16'hffff, 16'hffff}, '0},
    '{1'b1, '{16'h0001, 16'h0000, 16'h0000, 16'hffff}, '{9'd0,   7'd0,   7'd0,   1'b0}},
    '{1'b1, '{16'h0001, 16'h0000, 16'h0000, 16'h0001}, '{9'd0,   7'd100, 7'd50,  1'b0}},
    '{1'b0, '{16'h8000, 16'h4000, 16'h0000, 16'h8000}, '0}
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_ready;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  pending_t pending_hsl [$];
  int       mismatches = 0;
  int       cycles = 0;
  int       hold_left = 0;
  int       items_sent = 0;

  clear_normalized_rgb_to_hsl DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pct_of_clear(input int unsigned color, input int unsigned clear);
    int unsigned p;
    p = (color * 100) / clear;
    return (p > 100) ? 100 : int'(p);
  endfunction

  function automatic result_t hsl_of(input sample_t s);
    result_t o;
    int      r, g, b, mx, mn, dif, sum, light, h, sat;
    o = '0;
    if (s.clear_count == '0) begin
      o.clear_zero = 1'b1;
      return o;
    end
    r  = pct_of_clear(s.red_count, s.clear_count);
    g  = pct_of_clear(s.green_count, s.clear_count);
    b  = pct_of_clear(s.blue_count, s.clear_count);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dif   = mx - mn;
    sum   = mx + mn;
    light = sum / 2;
    o.lightness_pct = light[PCT_BITS-1:0];
    if (dif != 0) begin
      // signed divide truncates toward zero, as the sector formula wants
      if (mx == r) begin
        h = (60 * (g - b)) / dif;
        if (g < b) h += 360;
      end else if (mx == g) begin
        h = (60 * (b - r)) / dif + 120;
      end else begin
        h = (60 * (r - g)) / dif + 240;
      end
      if (h < 0) h = 0;
      if (h > 360) h = 360;
      if (light <= 50) begin
        sat = (dif * 100) / sum;
      end else begin
        sat = (200 - sum == 0) ? 0 : (dif * 100) / (200 - sum);
      end
      if (sat > 100) sat = 100;
      o.hue_degrees    = h[HUE_BITS-1:0];
      o.saturation_pct = sat[PCT_BITS-1:0];
    end
    return o;
  endfunction

  // mostly short gaps, now and then a long one, none at all when quiet
  function automatic int idle_cycles(input bit quiet);
    int pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic sample_t random_sample();
    sample_t     s;
    int          mode;
    int unsigned cap;
    mode = $urandom_range(0, 99);
    s.red_count   = 16'($urandom);
    s.green_count = 16'($urandom);
    s.blue_count  = 16'($urandom);
    s.clear_count = 16'($urandom);
    if (mode < 5) begin
      s.clear_count = '0;
    end else if (mode < 15) begin
      // raw counts as they come, mostly clamped
    end else begin
      if (s.clear_count == '0) s.clear_count = 16'd1;
      if ($urandom_range(0, 3) == 0) s.clear_count = 16'($urandom_range(1, 255));
      // keep colours around the clear level so the percents spread out
      cap = s.clear_count + s.clear_count / 8;
      if (cap > 65535) cap = 65535;
      s.red_count   = 16'($urandom_range(0, cap));
      s.green_count = 16'($urandom_range(0, cap));
      s.blue_count  = 16'($urandom_range(0, cap));
      if (mode < 25) begin
        s.green_count = s.red_count;
        s.blue_count  = s.red_count;
      end else if (mode < 35) begin
        case ($urandom_range(0, 2))
          0: s.green_count = s.red_count;
          1: s.blue_count  = s.green_count;
          default: s.blue_count = s.red_count;
        endcase
      end
    end
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input sample_t s, input bit typed, input result_t hand);
    int       gap;
    pending_t p;
    gap = idle_cycles(((items_sent / 64) % 4) == 3);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (!sample_ready);
    p.s = s;
    p.r = typed ? hand : hsl_of(s);
    pending_hsl.push_back(p);
    items_sent++;
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      result_ready <= 1'b1;
      hold_left = idle_cycles(((cycles / 300) % 4) == 1);
    end
  end

  always @(posedge clk) begin
    pending_t p;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && result_valid && result_ready) begin
      if (pending_hsl.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %p", $time, result);
        mismatches++;
      end else begin
        p = pending_hsl.pop_front();
        if (result.hue_degrees !== p.r.hue_degrees) begin
          $display("%0t hue_degrees for %p: expected %0d, actual %0d",
                   $time, p.s, p.r.hue_degrees, result.hue_degrees);
          mismatches++;
        end
        if (result.saturation_pct !== p.r.saturation_pct) begin
          $display("%0t saturation_pct for %p: expected %0d, actual %0d",
                   $time, p.s, p.r.saturation_pct, result.saturation_pct);
          mismatches++;
        end
        if (result.lightness_pct !== p.r.lightness_pct) begin
          $display("%0t lightness_pct for %p: expected %0d, actual %0d",
                   $time, p.s, p.r.lightness_pct, result.lightness_pct);
          mismatches++;
        end
        if (result.clear_zero !== p.r.clear_zero) begin
          $display("%0t clear_zero for %p: expected %0d, actual %0d",
                   $time, p.s, p.r.clear_zero, result.clear_zero);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int i = 0; i < N_ROWS; i++) begin
      send_sample(DIRECTED[i].s, DIRECTED[i].typed, DIRECTED[i].r);
    end
    for (int i = 0; i < RANDOM_SAMPLES; i++) begin
      send_sample(random_sample(), 1'b0, '0);
    end
    sample_valid <= 1'b0;
    while (pending_hsl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
